// ===== hdl/slea_pkg.sv =====
// Shared widths, command codes and defaults for the sound level envelope averager.
package slea_pkg;

    localparam int CMD_W    = 2;
    localparam int SAMPLE_W = 10;
    localparam int LEVEL_W  = 11;

    localparam logic [CMD_W-1:0] CMD_BEGIN   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CALIB   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd2;

    localparam logic [LEVEL_W-1:0] OFFSET_BIAS = 11'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 11'd1123;

    localparam int WINDOW_LEN_DEF    = 15;
    localparam int CALIB_SAMPLES_DEF = 10;

endpackage

// ===== hdl/slea_cdiv.sv =====
// Truncating division by a constant through a multiply by a rounded-up reciprocal.
module slea_cdiv #(
    parameter int XW      = 16,
    parameter int DIVISOR = 9,
    parameter int QW      = 10
) (
    input  logic [XW-1:0] x,
    output logic [QW-1:0] q
);

    localparam int SH = XW + $clog2(DIVISOR);
    localparam int PW = 2 * XW + 1;
    localparam longint unsigned MULT_L =
        ((64'd1 << SH) + longint'(DIVISOR) - 64'd1) / longint'(DIVISOR);
    localparam logic [XW:0] MULT = MULT_L[XW:0];

    logic [PW-1:0] prod;

    assign prod = PW'(x) * PW'(MULT);
    assign q    = prod[SH +: QW];

endmodule

// ===== hdl/slea_window.sv =====
// Sliding window of rectified samples as a parallel shift line with a running sum.
module slea_window
    import slea_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    parameter int SUM_W      = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [LEVEL_W-1:0] rect,
    output logic [SUM_W-1:0]   sum
);

    logic [LEVEL_W-1:0] tap_reg [WINDOW_LEN];
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;

    // drop the oldest entry, add the newest
    always_comb
    begin
        sum_next = sum_reg - SUM_W'(tap_reg[WINDOW_LEN-1]) + SUM_W'(rect);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                tap_reg[i] <= '0;
            end
            sum_reg <= '0;
        end
        else if (push)
        begin
            tap_reg[0] <= rect;
            for (int i = 1; i < WINDOW_LEN; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ===== hdl/sound_level_envelope_averager_top.sv =====
// Top level of the sound level envelope averager: calibration, rectify, window and output stage.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------
//  request  | req_valid / req_stall | command[1:0], sample[9:0]
//  response | rsp_valid / rsp_stall | level[10:0]
//
// One item per clock while req_stall is low. A measurement item right after the final
// calibration item waits in the input register while the offset divider (multiply by
// reciprocal of CALIB_SAMPLES-1) runs. A level passes the window and result registers.
// Reset clears valids, calibration and window at once, not data registers; no clearing pass.
// rsp_stall holds the result register and backs up through the window stage to req_stall.
module sound_level_envelope_averager_top
    import slea_pkg::*;
#(
    parameter int WINDOW_LEN    = WINDOW_LEN_DEF,
    parameter int CALIB_SAMPLES = CALIB_SAMPLES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [CMD_W-1:0]    command,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [LEVEL_W-1:0]  level
);

    localparam int CALIB_DIV = CALIB_SAMPLES - 1;
    localparam int CNT_W     = $clog2(CALIB_SAMPLES);
    localparam int CSUM_W    = $clog2(CALIB_DIV * ((1 << SAMPLE_W) - 1) + 1);
    localparam int SUM_W     = $clog2(WINDOW_LEN * ((1 << LEVEL_W) - 1) + 1);
    localparam logic [CNT_W-1:0] CALIB_LAST = CNT_W'(CALIB_DIV);

    logic                s0_valid_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [LEVEL_W-1:0]  level_reg;

    logic [CSUM_W-1:0]   calib_sum_reg;
    logic [CSUM_W-1:0]   calib_sum_next;
    logic [CNT_W-1:0]    calib_cnt_reg;
    logic [CNT_W-1:0]    calib_cnt_next;
    logic                calib_pend_reg;
    logic                calib_pend_next;
    logic [LEVEL_W-1:0]  offset_reg;
    logic [LEVEL_W-1:0]  offset_next;

    logic                s0_is_meas;
    logic                s1_busy;
    logic                s0_hold;
    logic                s0_fire;
    logic                meas_fire;
    logic                s1_adv;
    logic [LEVEL_W-1:0]  sample_ext;
    logic [LEVEL_W-1:0]  rect;
    logic [SAMPLE_W-1:0] cal_quo;
    logic [SUM_W-1:0]    window_sum;
    logic [LEVEL_W-1:0]  lvl_quo;

    assign s0_is_meas = (cmd_reg == CMD_MEASURE);
    assign s1_busy    = s1_valid_reg & out_valid_reg & rsp_stall;
    assign s0_hold    = s0_valid_reg & s0_is_meas & (calib_pend_reg | s1_busy);
    assign s0_fire    = s0_valid_reg & ~s0_hold;
    assign meas_fire  = s0_fire & s0_is_meas;
    assign s1_adv     = s1_valid_reg & ~(out_valid_reg & rsp_stall);
    assign req_stall  = s0_hold;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_hold | req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            cmd_reg    <= command;
            sample_reg <= sample;
        end
    end

    // calibration
    slea_cdiv #(
        .XW      (CSUM_W),
        .DIVISOR (CALIB_DIV),
        .QW      (SAMPLE_W)
    ) u_cal_div (
        .x (calib_sum_reg),
        .q (cal_quo)
    );

    always_comb
    begin
        calib_sum_next  = calib_sum_reg;
        calib_cnt_next  = calib_cnt_reg;
        calib_pend_next = 1'b0;
        offset_next     = calib_pend_reg ? (LEVEL_W'(cal_quo) + OFFSET_BIAS) : offset_reg;
        if (s0_fire)
        begin
            case (cmd_reg)
                CMD_BEGIN:
                begin
                    calib_sum_next = '0;
                    calib_cnt_next = '0;
                end
                CMD_CALIB:
                begin
                    if (calib_cnt_reg < CALIB_LAST)
                    begin
                        calib_sum_next  = calib_sum_reg + CSUM_W'(sample_reg);
                        calib_cnt_next  = calib_cnt_reg + CNT_W'(1);
                        calib_pend_next = (calib_cnt_next == CALIB_LAST);
                    end
                end
                CMD_MEASURE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_sum_reg  <= '0;
            calib_cnt_reg  <= '0;
            calib_pend_reg <= 1'b0;
            offset_reg     <= '0;
        end
        else
        begin
            calib_sum_reg  <= calib_sum_next;
            calib_cnt_reg  <= calib_cnt_next;
            calib_pend_reg <= calib_pend_next;
            offset_reg     <= offset_next;
        end
    end

    // rectify and push into the window
    assign sample_ext = LEVEL_W'(sample_reg);
    assign rect       = (sample_ext >= offset_reg) ? (sample_ext - offset_reg)
                                                   : (offset_reg - sample_ext);

    slea_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (meas_fire),
        .rect  (rect),
        .sum   (window_sum)
    );

    // average and result register
    slea_cdiv #(
        .XW      (SUM_W),
        .DIVISOR (WINDOW_LEN),
        .QW      (LEVEL_W)
    ) u_lvl_div (
        .x (window_sum),
        .q (lvl_quo)
    );

    assign s1_valid_next  = meas_fire | (s1_valid_reg & ~s1_adv);
    assign out_valid_next = s1_adv | (out_valid_reg & rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            level_reg <= lvl_quo;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign level     = level_reg;

endmodule

// ===== hdl/slea_checker.sv =====
// Port-level checks for the sound level envelope averager, bound to the top level.
module slea_checker
    import slea_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input logic [CMD_W-1:0]    command,
    input logic [SAMPLE_W-1:0] sample,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input logic [LEVEL_W-1:0]  level
);

    logic [CMD_W+SAMPLE_W-1:0] req_payload;

    assign req_payload = {command, sample};

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(level))
    else $error("stalled item changed");

    // level never exceeds the rectified range
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> level <= LEVEL_MAX)
    else $error("level out of range");

    // offset wait lasts a single cycle when the output drains
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall && !rsp_stall |=> !(req_stall && !rsp_stall))
    else $error("input stalled two cycles with output free");

    // stall only starts on an item just taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(req_stall) |-> $past(req_valid) && !$isunknown(req_payload))
    else $error("stall without an accepted item");

endmodule

bind sound_level_envelope_averager_top slea_checker u_slea_checker (.*);

// ===== tb/sound_level_envelope_averager_top_test.sv =====
// Self-checking testbench for the sound level envelope averager: random and directed items.
module sound_level_envelope_averager_top_test;
    import slea_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int WIN_DEPTH      = WINDOW_LEN_DEF;
    localparam int CAL_TAKE       = CALIB_SAMPLES_DEF - 1;
    localparam int ITEM_TARGET    = 1850;
    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 8;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [SAMPLE_W-1:0] smp;
        bit                  drain;
    } sensor_item_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic [CMD_W-1:0]    command = CMD_BEGIN;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [LEVEL_W-1:0]  level;

    sensor_item_t       pending_q[$];
    logic [LEVEL_W-1:0] level_q[$];
    sensor_item_t       nxt;
    int                 total_items;
    int                 acc_count;
    int                 err_count;
    int                 quiet;
    int                 hold_left;
    bit                 hold_done;
    logic [LEVEL_W-1:0] exp_lvl;

    logic [LEVEL_W-1:0] dc_offset = '0;
    logic [13:0]        cal_sum = '0;
    logic [3:0]         cal_cnt = '0;
    logic [LEVEL_W-1:0] win [WIN_DEPTH] = '{default: '0};
    logic [14:0]        win_sum = '0;
    int                 win_head = 0;

    sound_level_envelope_averager_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .command   (command),
        .sample    (sample),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .level     (level)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
        err_count++;
    endtask

    task automatic predict_level(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_W-1:0] smp);
        logic [LEVEL_W-1:0] rect;
        case (cmd)
            CMD_BEGIN:
            begin
                cal_sum = '0;
                cal_cnt = '0;
            end
            CMD_CALIB:
            begin
                if (cal_cnt < 4'(CAL_TAKE))
                begin
                    cal_sum = cal_sum + 14'(smp);
                    cal_cnt = cal_cnt + 4'd1;
                    if (cal_cnt == 4'(CAL_TAKE))
                        dc_offset = LEVEL_W'(int'(cal_sum) / CAL_TAKE + int'(OFFSET_BIAS));
                end
            end
            CMD_MEASURE:
            begin
                if ({1'b0, smp} >= dc_offset)
                    rect = {1'b0, smp} - dc_offset;
                else
                    rect = dc_offset - {1'b0, smp};
                win_sum = win_sum - 15'(win[win_head]) + 15'(rect);
                win[win_head] = rect;
                win_head = (win_head == WIN_DEPTH - 1) ? 0 : win_head + 1;
                level_q.push_back(LEVEL_W'(int'(win_sum) / WIN_DEPTH));
            end
            default: ;
        endcase
    endtask

    function automatic int tx_gap_pct();
        if (acc_count < total_items / 3)
            return 22;
        if (acc_count < 2 * total_items / 3)
            return 65;
        return 0;
    endfunction

    function automatic int rx_stall_pct();
        if (acc_count < total_items / 3)
            return 65;
        if (acc_count < 2 * total_items / 3)
            return 22;
        return 0;
    endfunction

    function automatic logic [SAMPLE_W-1:0] near(input int center, input int spread);
        int v;
        v = center - spread + int'($urandom_range(2 * spread));
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return SAMPLE_W'(v);
    endfunction

    function automatic logic [SAMPLE_W-1:0] measure_sample(input int base);
        case ($urandom_range(3))
            0: return SAMPLE_W'($urandom_range(1023));
            1: return near(base + 100, 30);
            2: return $urandom_range(1) ? SAMPLE_W'(1023) : SAMPLE_W'(0);
            default: return near(base, 200);
        endcase
    endfunction

    task automatic add_item(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_W-1:0] smp);
        sensor_item_t it;
        it.cmd = cmd;
        it.smp = smp;
        it.drain = 1'b0;
        pending_q.push_back(it);
    endtask

    task automatic build_stimulus();
        int kind;
        int base;
        int n;
        // calibration before any begin, then extras, offset held across repeated begin
        add_item(CMD_MEASURE, 10'd0);
        add_item(CMD_MEASURE, 10'd1023);
        add_item(CMD_UNUSED, 10'd1023);
        repeat (CAL_TAKE) add_item(CMD_CALIB, 10'd1023);
        add_item(CMD_CALIB, 10'd0);
        add_item(CMD_MEASURE, 10'd0);
        add_item(CMD_MEASURE, 10'd1023);
        add_item(CMD_BEGIN, 10'd1023);
        add_item(CMD_BEGIN, 10'd0);
        repeat (3) add_item(CMD_CALIB, 10'd0);
        add_item(CMD_MEASURE, 10'd512);
        while (pending_q.size() < ITEM_TARGET)
        begin
            kind = $urandom_range(99);
            base = $urandom_range(1023);
            if (kind < 70)
            begin
                add_item(CMD_BEGIN, SAMPLE_W'($urandom_range(1023)));
                n = CAL_TAKE + $urandom_range(2);
                repeat (n) add_item(CMD_CALIB, near(base, 25));
                n = $urandom_range(60, 5);
                repeat (n) add_item(CMD_MEASURE, measure_sample(base));
            end
            else if (kind < 80)
            begin
                if ($urandom_range(1))
                    add_item(CMD_BEGIN, SAMPLE_W'($urandom_range(1023)));
                n = $urandom_range(CAL_TAKE - 1, 1);
                repeat (n) add_item(CMD_CALIB, near(base, 25));
                n = $urandom_range(20, 1);
                repeat (n) add_item(CMD_MEASURE, measure_sample(base));
            end
            else if (kind < 90)
            begin
                n = $urandom_range(30, 1);
                repeat (n) add_item(CMD_MEASURE, measure_sample(base));
            end
            else
            begin
                n = $urandom_range(4, 1);
                repeat (n) add_item(CMD_MEASURE + 2'($urandom_range(1)) + 2'($urandom_range(1)),
                                    SAMPLE_W'($urandom_range(1023)));
            end
        end
        pending_q[pending_q.size() / 2].drain = 1'b1;
        total_items = pending_q.size();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            command   <= CMD_BEGIN;
            sample    <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                predict_level(command, sample);
                acc_count++;
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_q.size() != 0 && !(pending_q[0].drain && level_q.size() != 0)
                    && $urandom_range(99) >= tx_gap_pct())
                begin
                    nxt = pending_q.pop_front();
                    req_valid <= 1'b1;
                    command   <= nxt.cmd;
                    sample    <= nxt.smp;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (level_q.size() == 0)
                    report_mismatch("unexpected level", -1, level);
                else
                begin
                    exp_lvl = level_q.pop_front();
                    if (level !== exp_lvl)
                        report_mismatch("level", exp_lvl, level);
                end
            end
            if (!hold_done && acc_count >= total_items / 6)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < rx_stall_pct());
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet <= 0;
        else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet <= 0;
        else if (quiet == WATCHDOG_LIMIT)
        begin
            $display("[sound_level_envelope_averager_top] ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        build_stimulus();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_q.size() != 0 || req_valid)
            @(posedge clk);
        while (level_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (level_q.size() != 0)
            report_mismatch("levels never produced", 0, level_q.size());
        if (err_count == 0)
            $display("[sound_level_envelope_averager_top] OK");
        else
            $display("[sound_level_envelope_averager_top] ERROR");
        $finish;
    end

endmodule
